// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the project checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- hw/rtl/rgbs_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbs_pkg
// shared types and constants of the running gaussian background subtractor
// ----------------------------------------------------------------------------
package rgbs_pkg;

	localparam int PIX_W              = 8;
	localparam int CFG_DATA_W         = 18;
	localparam int CFG_IDX_W          = 2;
	localparam int MAX_PIXELS_DEFAULT = 131072;
	localparam int FRAME_PIXELS_RESET = 76800;

	localparam logic [8:0] ALPHA_RESET     = 9'd13;
	localparam logic [8:0] ALPHA_ONE       = 9'd256;
	localparam logic [7:0] THRESHOLD_RESET = 8'd48;
	localparam logic [7:0] INIT_VAR_RESET  = 8'd64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALPHA        = 2'd0,
		CFG_THRESHOLD    = 2'd1,
		CFG_INIT_VAR     = 2'd2,
		CFG_FRAME_PIXELS = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		FUNC_LOAD    = 1'b0,
		FUNC_SEGMENT = 1'b1
	} func_t;

	// settings as the datapath consumes them
	typedef struct packed {
		logic [8:0]  alpha;     // saturated learning rate
		logic [8:0]  beta;      // 256 - alpha
		logic [15:0] k2;        // threshold squared
		logic [7:0]  init_var;
	} cfg_t;

endpackage

// ----- hw/rtl/rgbs_ram.sv -----
// ----------------------------------------------------------------------------
// rgbs_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module rgbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/rgbs_cfg.sv -----
// ----------------------------------------------------------------------------
// rgbs_cfg
// configuration registers, kept in the form the datapath uses
// ----------------------------------------------------------------------------
module rgbs_cfg #(
	parameter int MAX_PIXELS = rgbs_pkg::MAX_PIXELS_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [rgbs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rgbs_pkg::CFG_DATA_W-1:0]       cfg_data,
	output rgbs_pkg::cfg_t                        regs,
	output logic [$clog2(MAX_PIXELS + 1)-1:0]     len
);

	localparam int LW = $clog2(MAX_PIXELS + 1);
	localparam int XW = (LW > rgbs_pkg::CFG_DATA_W) ? LW : rgbs_pkg::CFG_DATA_W;
	localparam int LEN_RESET = (rgbs_pkg::FRAME_PIXELS_RESET > MAX_PIXELS) ?
		MAX_PIXELS : rgbs_pkg::FRAME_PIXELS_RESET;
	localparam logic [15:0] K2_RESET =
		16'(rgbs_pkg::THRESHOLD_RESET) * 16'(rgbs_pkg::THRESHOLD_RESET);

	logic [8:0]    alpha_q;
	logic [15:0]   k2_q;
	logic [7:0]    init_var_q;
	logic [LW-1:0] len_q;

	logic [8:0]    alpha_d;
	logic [15:0]   k2_d;
	logic [XW-1:0] frame_x;
	logic [LW-1:0] len_d;

	always_comb begin
		alpha_d = (cfg_data[8:0] > rgbs_pkg::ALPHA_ONE) ? rgbs_pkg::ALPHA_ONE : cfg_data[8:0];
		k2_d    = 16'(cfg_data[7:0]) * 16'(cfg_data[7:0]);
		frame_x = XW'(cfg_data);
		if (frame_x == '0) begin
			len_d = LW'(1);
		end else if (frame_x > XW'(MAX_PIXELS)) begin
			len_d = LW'(MAX_PIXELS);
		end else begin
			len_d = LW'(frame_x);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q    <= rgbs_pkg::ALPHA_RESET;
			k2_q       <= K2_RESET;
			init_var_q <= rgbs_pkg::INIT_VAR_RESET;
			len_q      <= LW'(LEN_RESET);
		end else if (cfg_we) begin
			case (rgbs_pkg::cfg_idx_t'(cfg_index))
				rgbs_pkg::CFG_ALPHA:        alpha_q    <= alpha_d;
				rgbs_pkg::CFG_THRESHOLD:    k2_q       <= k2_d;
				rgbs_pkg::CFG_INIT_VAR:     init_var_q <= cfg_data[7:0];
				rgbs_pkg::CFG_FRAME_PIXELS: len_q      <= len_d;
				default:                    len_q      <= len_q;
			endcase
		end
	end

	assign regs.alpha    = alpha_q;
	assign regs.beta     = rgbs_pkg::ALPHA_ONE - alpha_q;
	assign regs.k2       = k2_q;
	assign regs.init_var = init_var_q;
	assign len           = len_q;

endmodule

// ----- hw/rtl/rgbs_pipe.sv -----
// ----------------------------------------------------------------------------
// rgbs_pipe
// pixel address, read-modify-write pipeline and result register
// ----------------------------------------------------------------------------
module rgbs_pipe #(
	parameter int MAX_PIXELS = rgbs_pkg::MAX_PIXELS_DEFAULT
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  rgbs_pkg::cfg_t                                    regs,
	input  logic [$clog2(MAX_PIXELS + 1)-1:0]                 len,
	input  logic                                              pixel_valid,
	output logic                                              pixel_ready,
	input  logic                                              func,
	input  logic [rgbs_pkg::PIX_W-1:0]                        pixel,
	input  logic                                              frame_start,
	output logic                                              result_valid,
	input  logic                                              result_ready,
	output logic                                              foreground,
	output logic                                              ram_re,
	output logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] ram_raddr,
	input  logic [2*rgbs_pkg::PIX_W-1:0]                      ram_rdata,
	output logic                                              ram_we,
	output logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] ram_waddr,
	output logic [2*rgbs_pkg::PIX_W-1:0]                      ram_wdata
);

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int LW = $clog2(MAX_PIXELS + 1);

	// address counter
	logic [AW-1:0] addr_q;
	logic [AW-1:0] addr_cur;
	logic [LW-1:0] addr_p1;
	logic          hazard;
	logic          accept;

	// stage occupancy
	logic v_s1, v_s2, v_s3, out_v_q;
	logic free1, free2, free3, out_free;

	// stage 1: ram data
	logic [AW-1:0]          addr_s1;
	logic [7:0]             pix_s1;
	rgbs_pkg::func_t        func_s1;
	logic [7:0]             mean_s1, var_s1, diff_s1;
	logic [15:0]            d2_s1;
	logic [23:0]            kv_s1;

	// stage 2: squares and products
	logic [AW-1:0]          addr_s2;
	logic [7:0]             pix_s2, mean_s2, var_s2;
	rgbs_pkg::func_t        func_s2;
	logic [15:0]            d2_s2;
	logic [23:0]            kv_s2;
	logic                   fg_s2;
	logic [16:0]            pa_s2, pb_s2, vb_s2;
	logic [24:0]            va_s2;

	// stage 3: sums and write-back
	logic [AW-1:0]          addr_s3;
	logic [7:0]             pix_s3;
	rgbs_pkg::func_t        func_s3;
	logic                   fg_s3;
	logic [15:0]            pa_s3, pb_s3, vb_s3;
	logic [24:0]            va_s3;
	logic [15:0]            msum_s3;
	logic [24:0]            vsum_s3;
	logic [7:0]             nv_s3;

	logic fg_q;

	// effective address of the offered pixel
	always_comb begin
		if (frame_start || (LW'(addr_q) >= len)) begin
			addr_cur = '0;
		end else begin
			addr_cur = addr_q;
		end
		addr_p1 = LW'(addr_cur) + LW'(1);
	end

	// a segment pixel may not read an entry an older pixel has yet to write
	assign hazard = (rgbs_pkg::func_t'(func) == rgbs_pkg::FUNC_SEGMENT) &&
		((v_s1 && (addr_s1 == addr_cur)) ||
		 (v_s2 && (addr_s2 == addr_cur)) ||
		 (v_s3 && (addr_s3 == addr_cur)));

	assign out_free    = !out_v_q || result_ready;
	assign free3       = !v_s3 || out_free;
	assign free2       = !v_s2 || free3;
	assign free1       = !v_s1 || free2;
	assign pixel_ready = free1 && !hazard;
	assign accept      = pixel_valid && pixel_ready;

	assign ram_re    = accept;
	assign ram_raddr = addr_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (accept) begin
			addr_q <= (addr_p1 >= len) ? '0 : AW'(addr_p1);
		end
	end

	// stage 1 compute
	assign {mean_s1, var_s1} = ram_rdata;
	always_comb begin
		diff_s1 = (pix_s1 >= mean_s1) ? (pix_s1 - mean_s1) : (mean_s1 - pix_s1);
		d2_s1   = 16'(diff_s1) * 16'(diff_s1);
		kv_s1   = 24'(regs.k2) * 24'(var_s1);
	end

	// stage 2 compute
	always_comb begin
		fg_s2 = (func_s2 == rgbs_pkg::FUNC_SEGMENT) && ({d2_s2, 8'h00} > kv_s2);
		pa_s2 = 17'(regs.alpha) * 17'(pix_s2);
		pb_s2 = 17'(regs.beta) * 17'(mean_s2);
		va_s2 = 25'(regs.alpha) * 25'(d2_s2);
		vb_s2 = 17'(regs.beta) * 17'(var_s2);
	end

	// stage 3 compute, alpha + beta = 256 keeps the mean within 8 bits
	always_comb begin
		msum_s3 = pa_s3 + pb_s3;
		vsum_s3 = va_s3 + 25'(vb_s3);
		nv_s3   = (|vsum_s3[24:16]) ? 8'hFF : vsum_s3[15:8];
		if (func_s3 == rgbs_pkg::FUNC_LOAD) begin
			ram_wdata = {pix_s3, regs.init_var};
		end else begin
			ram_wdata = {msum_s3[15:8], nv_s3};
		end
	end

	assign ram_we    = v_s3 && out_free && ((func_s3 == rgbs_pkg::FUNC_LOAD) || !fg_s3);
	assign ram_waddr = addr_s3;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (free1) begin
				v_s1 <= accept;
			end
			if (free2) begin
				v_s2 <= v_s1;
			end
			if (free3) begin
				v_s3 <= v_s2;
			end
			if (out_free) begin
				out_v_q <= v_s3;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= addr_cur;
			pix_s1  <= pixel;
			func_s1 <= rgbs_pkg::func_t'(func);
		end
		if (free2 && v_s1) begin
			addr_s2 <= addr_s1;
			pix_s2  <= pix_s1;
			func_s2 <= func_s1;
			mean_s2 <= mean_s1;
			var_s2  <= var_s1;
			d2_s2   <= d2_s1;
			kv_s2   <= kv_s1;
		end
		if (free3 && v_s2) begin
			addr_s3 <= addr_s2;
			pix_s3  <= pix_s2;
			func_s3 <= func_s2;
			fg_s3   <= fg_s2;
			pa_s3   <= pa_s2[15:0];
			pb_s3   <= pb_s2[15:0];
			va_s3   <= va_s2;
			vb_s3   <= vb_s2[15:0];
		end
		if (out_free && v_s3) begin
			fg_q <= fg_s3;
		end
	end

	assign result_valid = out_v_q;
	assign foreground   = fg_q;

endmodule

// ----- hw/rtl/running_gaussian_background_subtract_unit.sv -----
// ----------------------------------------------------------------------------
// running_gaussian_background_subtract_unit
// per-pixel running gaussian background model with foreground decision
// ----------------------------------------------------------------------------
// Gray pixels enter in raster order, at most one per clock. A load pixel
// (func 0) stores the pixel as the background mean and the initial variance;
// a segment pixel (func 1) reports foreground when 256*(pixel-mean)^2 exceeds
// threshold^2*variance and, for background pixels only, blends mean and
// variance with rate alpha/256. Mean and variance live in one ram of
// MAX_PIXELS 16-bit entries with a registered read; an entry must be
// written by a load pass before a segment pass reads it, and the ram is
// never cleared. A result passes the ram read with square, compare with
// blend products, sums with write-back and the result register. Sustained
// rate is one pixel per clock unless results are held back or a segment
// pixel waits. A segment pixel whose address is still being written by one
// of the three pixels ahead of it waits until that write lands, so segment
// frames of one, two or three pixels run below that rate; load pixels never
// wait for this. frame_start forces address 0; the address wraps at
// frame_pixels (0 acts as 1, values above MAX_PIXELS are clamped).
// Configuration writes are taken at any time but are meant for idle periods.
module running_gaussian_background_subtract_unit #(
	parameter int MAX_PIXELS = rgbs_pkg::MAX_PIXELS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [rgbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rgbs_pkg::CFG_DATA_W-1:0]   cfg_data,
	// pixel channel
	input  logic                              pixel_valid,
	output logic                              pixel_ready,
	input  logic                              func,
	input  logic [rgbs_pkg::PIX_W-1:0]        pixel,
	input  logic                              frame_start,
	// result channel
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic                              foreground
);

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int LW = $clog2(MAX_PIXELS + 1);
	localparam int DW = 2 * rgbs_pkg::PIX_W;

	rgbs_pkg::cfg_t regs;
	logic [LW-1:0]  len;

	// ram request lines, {mean, variance} per entry
	logic          ram_re, ram_we;
	logic [AW-1:0] ram_raddr, ram_waddr;
	logic [DW-1:0] ram_rdata, ram_wdata;

	// settings, precomputed into saturated alpha, 256-alpha and threshold^2
	rgbs_cfg #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs),
		.len       (len)
	);

	// address generation, interlock and the read-modify-write stages
	rgbs_pipe #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.regs         (regs),
		.len          (len),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.func         (func),
		.pixel        (pixel),
		.frame_start  (frame_start),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.foreground   (foreground),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata)
	);

	// background model store
	rgbs_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_PIXELS)
	) u_model_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// ----- hw/rtl/rgbs_checker.sv -----
// ----------------------------------------------------------------------------
// rgbs_checker
// port-level checks of the background subtractor, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgbs_checker (
	input logic clk,
	input logic arst_n,
	input logic pixel_valid,
	input logic pixel_ready,
	input logic result_valid,
	input logic result_ready,
	input logic foreground
);

	// pixels taken but results not yet delivered
	logic [2:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(pixel_valid && pixel_ready)
				- 3'(result_valid && result_ready);
		end
	end

	// a stalled result holds its value
	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(foreground))

	// never more pixels in flight than pipeline slots
	`ASSERT_IMPL(a_depth, clk, arst_n, 1'b1, inflight_q <= 3'd4)

	// an empty pipeline always takes the next pixel
	`ASSERT_IMPL(a_empty_ready, clk, arst_n, (inflight_q == 3'd0) && pixel_valid, pixel_ready)

	// no result without a pixel behind it
	`ASSERT_IMPL(a_no_phantom, clk, arst_n, result_valid, inflight_q != 3'd0)

endmodule

bind running_gaussian_background_subtract_unit rgbs_checker u_rgbs_checker (.*);

// ----- verif/tb_running_gaussian_background_subtract_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_running_gaussian_background_subtract_unit
// self-checking bench for the running gaussian background subtractor
// ----------------------------------------------------------------------------
// A queue of pending pixels feeds a clocked driver; every pixel transfer is
// run through a local background model that predicts the foreground bit.
// A clocked monitor compares each result transfer with the oldest
// prediction. A short directed part hits the boundary and saturation cases;
// random phases then rewrite all settings and send load frames followed by
// segment frames whose pixels sit near the loaded scene, with some noise.
// ----------------------------------------------------------------------------
module tb_running_gaussian_background_subtract_unit;
	import rgbs_pkg::*;

	localparam int MAX_PIX      = MAX_PIXELS_DEFAULT;
	localparam int RESET_CYCLES = 8;
	localparam int DRAIN_CYCLES = 12;     // time allowed after the last result
	localparam int CYCLE_LIMIT  = 600000;
	localparam int PHASE_ITEMS  = 125;
	localparam int PRINT_LIMIT  = 40;

	typedef struct {
		func_t      f;
		logic [7:0] pix;
		logic       start;
	} pixel_item_t;

	// dut signals
	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	cfg_idx_t              cfg_index    = CFG_ALPHA;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  pixel_valid  = 1'b0;
	logic                  pixel_ready;
	func_t                 func         = FUNC_LOAD;
	logic [PIX_W-1:0]      pixel        = '0;
	logic                  frame_start  = 1'b0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	logic                  foreground;

	// background model: settings, per-pixel mean and variance, address
	logic [8:0]  alpha_cfg    = ALPHA_RESET;
	logic [7:0]  thresh_cfg   = THRESHOLD_RESET;
	logic [7:0]  init_var_cfg = INIT_VAR_RESET;
	logic [17:0] frame_cfg    = 18'(FRAME_PIXELS_RESET);
	logic [7:0]  bg_mean [MAX_PIX];
	logic [7:0]  bg_var  [MAX_PIX];
	int          bg_addr      = 0;

	// stimulus bookkeeping: which entries a load has written, and what scene
	bit          loaded [MAX_PIX];
	logic [7:0]  scene  [MAX_PIX];
	int          gen_addr     = 0;
	int          gen_count    = 0;

	pixel_item_t pixel_q[$];      // pixels not yet offered
	logic        fg_q[$];         // predicted foreground bits in order

	int          errors       = 0;
	int          cycles       = 0;
	bit          idle_on      = 1'b0;
	int          send_gap     = 0;
	int          recv_gap     = 0;

	running_gaussian_background_subtract_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.func         (func),
		.pixel        (pixel),
		.frame_start  (frame_start),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.foreground   (foreground)
	);

	always #5 clk = ~clk;

	// frame length as the block uses it: zero acts as one, clamp at the ram size
	function automatic int frame_len();
		int n;
		n = int'(frame_cfg);
		if (n == 0) n = 1;
		if (n > MAX_PIX) n = MAX_PIX;
		return n;
	endfunction

	// address of the next pixel, given the running address
	function automatic int slot_of(logic start, int cur);
		if (start || cur >= frame_len()) return 0;
		return cur;
	endfunction

	function automatic int next_slot(int a);
		return (a + 1 >= frame_len()) ? 0 : a + 1;
	endfunction

	// one pixel through the background model; returns the foreground bit
	function automatic logic classify_pixel(pixel_item_t it);
		int   a, p, m, v, k, diff, d2, w, nm, nv;
		logic fg;
		fg = 1'b0;
		a  = slot_of(it.start, bg_addr);
		p  = int'(it.pix);
		if (it.f == FUNC_LOAD) begin
			bg_mean[a] = it.pix;
			bg_var[a]  = init_var_cfg;
		end else begin
			m    = int'(bg_mean[a]);
			v    = int'(bg_var[a]);
			k    = int'(thresh_cfg);
			diff = (p >= m) ? p - m : m - p;
			d2   = diff * diff;
			fg   = (256 * d2 > k * k * v);
			// only background pixels pull the model along
			if (!fg) begin
				w  = (int'(alpha_cfg) > 256) ? 256 : int'(alpha_cfg);
				nm = (w * p + (256 - w) * m) >> 8;
				nv = (w * d2 + (256 - w) * v) >> 8;
				if (nm > 255) nm = 255;
				if (nv > 255) nv = 255;
				bg_mean[a] = 8'(nm);
				bg_var[a]  = 8'(nv);
			end
		end
		bg_addr = next_slot(a);
		return fg;
	endfunction

	// mostly short gaps, a few long ones, none while idling is off
	function automatic int pick_gap();
		int r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// pixel near the loaded scene value of an entry
	function automatic logic [7:0] near_scene(int a, int spread);
		int p;
		p = int'(scene[a]) + int'($urandom_range(0, 2 * spread)) - spread;
		if (p < 0) p = 0;
		if (p > 255) p = 255;
		return 8'(p);
	endfunction

	// queue one pixel; a segment at an entry never loaded turns into a load
	task automatic queue_pixel(func_t f, logic [7:0] pix, logic start);
		pixel_item_t it;
		int          a;
		a = slot_of(start, gen_addr);
		if (f == FUNC_SEGMENT && !loaded[a]) f = FUNC_LOAD;
		if (f == FUNC_LOAD) begin
			loaded[a] = 1'b1;
			scene[a]  = pix;
		end
		it.f     = f;
		it.pix   = pix;
		it.start = start;
		pixel_q.push_back(it);
		gen_addr = next_slot(a);
		gen_count++;
	endtask

	task automatic write_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_ALPHA:        alpha_cfg    = val[8:0];
			CFG_THRESHOLD:    thresh_cfg   = val[7:0];
			CFG_INIT_VAR:     init_var_cfg = val[7:0];
			CFG_FRAME_PIXELS: frame_cfg    = val[17:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [8:0] alpha, logic [7:0] thr, logic [7:0] ivar,
		logic [17:0] frames);
		write_cfg(CFG_ALPHA, CFG_DATA_W'(alpha));
		write_cfg(CFG_THRESHOLD, CFG_DATA_W'(thr));
		write_cfg(CFG_INIT_VAR, CFG_DATA_W'(ivar));
		write_cfg(CFG_FRAME_PIXELS, frames);
	endtask

	// sender holds off until every predicted result has come back;
	// checked on the falling edge so the rising-edge updates have settled
	task automatic wait_idle();
		while (pixel_q.size() != 0 || pixel_valid || fg_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic report_mismatch(string msg);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	// pixel driver: predicts at each transfer, then offers the next pixel
	always @(posedge clk or negedge arst_n) begin : pixel_driver
		pixel_item_t it;
		if (!arst_n) begin
			pixel_valid <= 1'b0;
			func        <= FUNC_LOAD;
			pixel       <= '0;
			frame_start <= 1'b0;
			send_gap     = 0;
		end else begin
			if (pixel_valid && pixel_ready) begin
				// payload is still on the wires at the transfer edge
				it.f     = func;
				it.pix   = pixel;
				it.start = frame_start;
				fg_q.push_back(classify_pixel(it));
			end
			// valid stays up with a steady payload until the transfer
			if (!pixel_valid || pixel_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					pixel_valid <= 1'b0;
				end else if (pixel_q.size() != 0) begin
					it           = pixel_q.pop_front();
					func        <= it.f;
					pixel       <= it.pix;
					frame_start <= it.start;
					pixel_valid <= 1'b1;
					send_gap     = pick_gap();
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: random backpressure, compare against oldest prediction
	always @(posedge clk or negedge arst_n) begin : result_monitor
		logic want;
		if (!arst_n) begin
			result_ready <= 1'b0;
			recv_gap      = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (fg_q.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending, foreground %b",
						foreground));
				end else begin
					want = fg_q.pop_front();
					if (foreground !== want)
						report_mismatch($sformatf("foreground %b, expected %b",
							foreground, want));
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				recv_gap      = pick_gap();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("running_gaussian_background_subtract_unit verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int          ph, span, len, i, a, spread, r;
		logic [8:0]  alpha_v;
		logic [7:0]  thr_v, ivar_v;
		logic [17:0] frame_v;
		bit          st;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: extremes of the pixel, and a deviation right on the
		// threshold (3 sd at variance 64 is 24 levels, which stays background)
		idle_on = 1'b0;
		queue_pixel(FUNC_LOAD, 8'd0, 1'b1);
		queue_pixel(FUNC_LOAD, 8'd255, 1'b0);
		queue_pixel(FUNC_LOAD, 8'd128, 1'b0);
		queue_pixel(FUNC_LOAD, 8'd77, 1'b0);
		queue_pixel(FUNC_SEGMENT, 8'd0, 1'b1);
		queue_pixel(FUNC_SEGMENT, 8'd255, 1'b0);
		queue_pixel(FUNC_SEGMENT, 8'd0, 1'b0);
		queue_pixel(FUNC_SEGMENT, 8'd101, 1'b0);
		wait_idle();

		// full rate, top threshold and variance, frame length zero acts as one:
		// every pixel hits the same entry back to back, variance saturates
		set_config(ALPHA_ONE, 8'd255, 8'd255, 18'd0);
		queue_pixel(FUNC_LOAD, 8'd200, 1'b1);
		queue_pixel(FUNC_SEGMENT, 8'd0, 1'b0);
		queue_pixel(FUNC_SEGMENT, 8'd255, 1'b0);
		queue_pixel(FUNC_SEGMENT, 8'd20, 1'b0);
		queue_pixel(FUNC_SEGMENT, 8'd0, 1'b0);
		wait_idle();

		// everything zero, three-pixel frame with a natural wrap
		idle_on = 1'b1;
		set_config(9'd0, 8'd0, 8'd0, 18'd3);
		queue_pixel(FUNC_LOAD, 8'd10, 1'b1);
		queue_pixel(FUNC_LOAD, 8'd20, 1'b0);
		queue_pixel(FUNC_LOAD, 8'd30, 1'b0);
		queue_pixel(FUNC_SEGMENT, 8'd10, 1'b0);
		queue_pixel(FUNC_SEGMENT, 8'd21, 1'b0);
		queue_pixel(FUNC_SEGMENT, 8'd30, 1'b0);
		wait_idle();

		// alpha above one clamps to one, frame above the ram size clamps;
		// the last pixel only stays background if the mean moved to 61
		set_config(9'h1FF, 8'h10, 8'd1, 18'h3FFFF);
		queue_pixel(FUNC_LOAD, 8'd50, 1'b1);
		queue_pixel(FUNC_LOAD, 8'd60, 1'b0);
		queue_pixel(FUNC_SEGMENT, 8'd52, 1'b1);
		queue_pixel(FUNC_SEGMENT, 8'd61, 1'b0);
		queue_pixel(FUNC_SEGMENT, 8'd50, 1'b1);
		queue_pixel(FUNC_SEGMENT, 8'd62, 1'b0);
		wait_idle();

		// random phases: new settings, one load frame, then segment frames and strays
		for (ph = 0; ph < 8; ph++) begin
			r = $urandom_range(0, 9);
			case (r)
				0:       alpha_v = 9'd0;
				1:       alpha_v = ALPHA_ONE;
				2:       alpha_v = 9'($urandom_range(257, 511));
				default: alpha_v = 9'($urandom_range(1, 64));
			endcase
			r = $urandom_range(0, 9);
			case (r)
				0:       thr_v = 8'd0;
				1:       thr_v = 8'd255;
				default: thr_v = 8'($urandom_range(16, 80));
			endcase
			r = $urandom_range(0, 9);
			case (r)
				0:       ivar_v = 8'd0;
				1:       ivar_v = 8'd255;
				default: ivar_v = 8'($urandom_range(1, 254));
			endcase
			r = $urandom_range(0, 9);
			case (r)
				0:       frame_v = 18'd0;
				1, 2:    frame_v = 18'($urandom_range(1, 3));
				8:       frame_v = 18'(MAX_PIX);
				9:       frame_v = 18'($urandom_range(MAX_PIX + 1, 262143));
				default: frame_v = 18'($urandom_range(4, 40));
			endcase
			set_config(alpha_v, thr_v, ivar_v, frame_v);

			len       = frame_len();
			span      = (len <= 40) ? len : int'($urandom_range(8, 40));
			spread    = int'($urandom_range(2, 30));
			idle_on   = ($urandom_range(0, 3) != 0);
			gen_count = 0;
			for (i = 0; i < span; i++)
				queue_pixel(FUNC_LOAD, 8'($urandom), i == 0);
			while (gen_count < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					// stray pixel: any function, any level, rare frame start
					queue_pixel(func_t'($urandom_range(0, 1)), 8'($urandom),
						$urandom_range(0, 3) == 0);
				end else begin
					for (i = 0; i < span; i++) begin
						// full frames may wrap by themselves, partial ones restart
						st = (i == 0) && (span < len || $urandom_range(0, 1) != 0);
						a  = slot_of(st, gen_addr);
						queue_pixel(FUNC_SEGMENT, near_scene(a, spread), st);
					end
				end
			end
			wait_idle();
		end

		if (errors == 0)
			$display("running_gaussian_background_subtract_unit verification clean");
		else
			$display("running_gaussian_background_subtract_unit verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/rgbs_pkg.sv
hw/rtl/rgbs_ram.sv
hw/rtl/rgbs_cfg.sv
hw/rtl/rgbs_pipe.sv
hw/rtl/running_gaussian_background_subtract_unit.sv
hw/rtl/rgbs_checker.sv
verif/tb_running_gaussian_background_subtract_unit.sv
